// ===== hw/rtl/pse_pkg.sv =====
`timescale 1ns / 1ps

package pse_pkg;

   localparam int MaxOrder = 8;
   localparam int FracBits = 16;
   localparam int IdxW     = $clog2(MaxOrder);
   localparam int CntW     = $clog2(MaxOrder + 1);

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_TERMS  = 2'd1;
   localparam logic [1:0] CSR_OFFSET = 2'd2;
   localparam logic [1:0] CSR_SCALE  = 2'd3;

   localparam logic [1:0] MODE_CHEB = 2'd1;
   localparam logic [1:0] MODE_LEG  = 2'd2;

   localparam logic CMD_EVAL = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [2:0] OP_S    = 3'd0;
   localparam logic [2:0] OP_PW   = 3'd1;
   localparam logic [2:0] OP_M_CH = 3'd2;
   localparam logic [2:0] OP_M_LG = 3'd3;
   localparam logic [2:0] OP_P1   = 3'd4;
   localparam logic [2:0] OP_P2   = 3'd5;
   localparam logic [2:0] OP_AC   = 3'd6;

   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FracBits;

   localparam logic signed [31:0] LEG_A [8] = '{
      32'sd0, 32'sd0,
      32'(((3 << FracBits) + 1) / 2), 32'(((5 << FracBits) + 1) / 3),
      32'(((7 << FracBits) + 2) / 4), 32'(((9 << FracBits) + 2) / 5),
      32'(((11 << FracBits) + 3) / 6), 32'(((13 << FracBits) + 3) / 7)};

   localparam logic signed [31:0] LEG_B [8] = '{
      32'sd0, 32'sd0,
      -32'(((1 << FracBits) + 1) / 2), -32'(((2 << FracBits) + 1) / 3),
      -32'(((3 << FracBits) + 2) / 4), -32'(((4 << FracBits) + 2) / 5),
      -32'(((5 << FracBits) + 3) / 6), -32'(((6 << FracBits) + 3) / 7)};

   typedef struct packed {
      logic            start;
      logic            load_en;
      logic            mul_en;
      logic            wb_en;
      logic [2:0]      op;
      logic [IdxW-1:0] idx;
      logic            out_ld;
   } pse_cmd_type;

   function automatic logic ovf34(input logic signed [33:0] v);
      return (v > 34'sh07FFFFFFF) || (v < -34'sh080000000);
   endfunction

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh07FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -34'sh080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/pse_ctrl.sv =====
`timescale 1ns / 1ps

module pse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [1:0]           series_mode,
   input  logic [3:0]           term_count,
   output pse_pkg::pse_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INIT  = 4'd1;
   localparam logic [3:0] ST_S_M   = 4'd2;
   localparam logic [3:0] ST_S_W   = 4'd3;
   localparam logic [3:0] ST_PW_M  = 4'd4;
   localparam logic [3:0] ST_PW_W  = 4'd5;
   localparam logic [3:0] ST_M_M   = 4'd6;
   localparam logic [3:0] ST_M_W   = 4'd7;
   localparam logic [3:0] ST_P1_M  = 4'd8;
   localparam logic [3:0] ST_P1_W  = 4'd9;
   localparam logic [3:0] ST_P2_M  = 4'd10;
   localparam logic [3:0] ST_P2_W  = 4'd11;
   localparam logic [3:0] ST_AC_M  = 4'd12;
   localparam logic [3:0] ST_AC_W  = 4'd13;
   localparam logic [3:0] ST_DONE  = 4'd14;

   logic [3:0]                   state_ff, state_in;
   logic [pse_pkg::CntW-1:0]     j_ff, j_in;
   logic [pse_pkg::CntW-1:0]     n_ff, n_in;
   logic                         orth_ff, orth_in;
   logic                         leg_ff, leg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;
   logic [pse_pkg::CntW-1:0]     n_clamp;
   logic [pse_pkg::CntW-1:0]     j_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign j_next    = j_ff + 1'b1;

   always_comb begin
      if (term_count == 4'd0) begin
         n_clamp = pse_pkg::CntW'(1);
      end else if (term_count > 4'(pse_pkg::MaxOrder)) begin
         n_clamp = pse_pkg::CntW'(pse_pkg::MaxOrder);
      end else begin
         n_clamp = pse_pkg::CntW'(term_count);
      end
   end

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      orth_in      = orth_ff;
      leg_in       = leg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.idx      = j_ff[pse_pkg::IdxW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == pse_pkg::CMD_LOAD) begin
                  cmd.load_en = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  n_in      = n_clamp;
                  orth_in   = (series_mode == pse_pkg::MODE_CHEB) ||
                              (series_mode == pse_pkg::MODE_LEG);
                  leg_in    = (series_mode == pse_pkg::MODE_LEG);
                  j_in      = pse_pkg::CntW'(1);
                  state_in  = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            if (orth_ff) begin
               state_in = ST_S_M;
            end else if (n_ff > pse_pkg::CntW'(1)) begin
               state_in = ST_AC_M;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_S_M: begin
            cmd.mul_en = 1'b1;
            cmd.op     = pse_pkg::OP_S;
            state_in   = ST_S_W;
         end
         ST_S_W: begin
            cmd.wb_en = 1'b1;
            cmd.op    = pse_pkg::OP_S;
            state_in  = (n_ff > pse_pkg::CntW'(1)) ? ST_AC_M : ST_DONE;
         end
         ST_PW_M: begin
            cmd.mul_en = 1'b1;
            cmd.op     = pse_pkg::OP_PW;
            state_in   = ST_PW_W;
         end
         ST_PW_W: begin
            cmd.wb_en = 1'b1;
            cmd.op    = pse_pkg::OP_PW;
            state_in  = ST_AC_M;
         end
         ST_M_M: begin
            cmd.mul_en = 1'b1;
            cmd.op     = leg_ff ? pse_pkg::OP_M_LG : pse_pkg::OP_M_CH;
            state_in   = ST_M_W;
         end
         ST_M_W: begin
            cmd.wb_en = 1'b1;
            cmd.op    = leg_ff ? pse_pkg::OP_M_LG : pse_pkg::OP_M_CH;
            state_in  = leg_ff ? ST_P1_M : ST_AC_M;
         end
         ST_P1_M: begin
            cmd.mul_en = 1'b1;
            cmd.op     = pse_pkg::OP_P1;
            state_in   = ST_P1_W;
         end
         ST_P1_W: begin
            cmd.wb_en = 1'b1;
            cmd.op    = pse_pkg::OP_P1;
            state_in  = ST_P2_M;
         end
         ST_P2_M: begin
            cmd.mul_en = 1'b1;
            cmd.op     = pse_pkg::OP_P2;
            state_in   = ST_P2_W;
         end
         ST_P2_W: begin
            cmd.wb_en = 1'b1;
            cmd.op    = pse_pkg::OP_P2;
            state_in  = ST_AC_M;
         end
         ST_AC_M: begin
            cmd.mul_en = 1'b1;
            cmd.op     = pse_pkg::OP_AC;
            state_in   = ST_AC_W;
         end
         ST_AC_W: begin
            cmd.wb_en = 1'b1;
            cmd.op    = pse_pkg::OP_AC;
            j_in      = j_next;
            if (j_next == n_ff) begin
               state_in = ST_DONE;
            end else if (orth_ff) begin
               state_in = ST_M_M;
            end else begin
               state_in = ST_PW_M;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         n_ff         <= pse_pkg::CntW'(1);
         orth_ff      <= 1'b0;
         leg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         orth_ff      <= orth_in;
         leg_ff       <= leg_in;
      end
   end

endmodule

// ===== hw/rtl/pse_dpath.sv =====
`timescale 1ns / 1ps

module pse_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  pse_pkg::pse_cmd_type         cmd,
   input  logic [pse_pkg::IdxW-1:0]     coeff_index,
   input  logic signed [31:0]           coeff_value,
   input  logic signed [31:0]           coord_x,
   input  logic signed [31:0]           norm_offset,
   input  logic signed [31:0]           norm_scale,
   output logic signed [31:0]           fit_value,
   output logic                         saturated
);

   logic signed [31:0] coeff_ff [pse_pkg::MaxOrder];
   logic signed [31:0] x_ff, v_ff, s_ff, tm1_ff, tm2_ff, t_ff, m_ff, p1_ff, acc_ff;
   logic signed [31:0] x_in, v_in, s_in, tm1_in, tm2_in, t_in, m_in, p1_in, acc_in;
   logic               flag_ff, flag_in;
   logic signed [63:0] prod_ff;
   logic signed [31:0] fit_ff;
   logic               sat_ff;
   logic signed [31:0] op_a, op_b;
   logic signed [63:0] shifted;
   logic signed [31:0] q;
   logic               q_ovf;
   logic signed [33:0] sum;
   logic signed [33:0] init_sum;

   assign fit_value = fit_ff;
   assign saturated = sat_ff;

   always_comb begin
      unique case (cmd.op)
         pse_pkg::OP_S: begin
            op_a = v_ff;
            op_b = norm_scale;
         end
         pse_pkg::OP_PW: begin
            op_a = t_ff;
            op_b = x_ff;
         end
         pse_pkg::OP_M_CH, pse_pkg::OP_M_LG: begin
            op_a = s_ff;
            op_b = tm1_ff;
         end
         pse_pkg::OP_P1: begin
            op_a = m_ff;
            op_b = pse_pkg::LEG_A[cmd.idx];
         end
         pse_pkg::OP_P2: begin
            op_a = tm2_ff;
            op_b = pse_pkg::LEG_B[cmd.idx];
         end
         default: begin
            op_a = t_ff;
            op_b = coeff_ff[cmd.idx];
         end
      endcase
   end

   always_comb begin
      shifted = prod_ff >>> pse_pkg::FracBits;
      q_ovf   = (shifted > 64'sh7FFFFFFF) || (shifted < -64'sh80000000);
      if (shifted > 64'sh7FFFFFFF) begin
         q = 32'sh7FFFFFFF;
      end else if (shifted < -64'sh80000000) begin
         q = 32'sh80000000;
      end else begin
         q = shifted[31:0];
      end
   end

   always_comb begin
      x_in     = x_ff;
      v_in     = v_ff;
      s_in     = s_ff;
      tm1_in   = tm1_ff;
      tm2_in   = tm2_ff;
      t_in     = t_ff;
      m_in     = m_ff;
      p1_in    = p1_ff;
      acc_in   = acc_ff;
      flag_in  = flag_ff;
      sum      = '0;
      init_sum = 34'(coord_x) + 34'(norm_offset);
      if (cmd.start) begin
         x_in    = coord_x;
         t_in    = coord_x;
         v_in    = pse_pkg::sat34(init_sum);
         tm1_in  = pse_pkg::ONE_Q;
         tm2_in  = pse_pkg::ONE_Q;
         acc_in  = coeff_ff[0];
         flag_in = 1'b0;
      end else if (cmd.wb_en) begin
         unique case (cmd.op)
            pse_pkg::OP_S: begin
               s_in    = q;
               t_in    = q;
               tm1_in  = pse_pkg::ONE_Q;
               tm2_in  = pse_pkg::ONE_Q;
               flag_in = flag_ff | q_ovf | pse_pkg::ovf34(34'(x_ff) + 34'(norm_offset));
            end
            pse_pkg::OP_PW: begin
               t_in    = q;
               flag_in = flag_ff | q_ovf;
            end
            pse_pkg::OP_M_CH: begin
               sum     = (34'(q) <<< 1) - 34'(tm2_ff);
               t_in    = pse_pkg::sat34(sum);
               flag_in = flag_ff | q_ovf | pse_pkg::ovf34(sum);
            end
            pse_pkg::OP_M_LG: begin
               m_in    = q;
               flag_in = flag_ff | q_ovf;
            end
            pse_pkg::OP_P1: begin
               p1_in   = q;
               flag_in = flag_ff | q_ovf;
            end
            pse_pkg::OP_P2: begin
               sum     = 34'(p1_ff) + 34'(q);
               t_in    = pse_pkg::sat34(sum);
               flag_in = flag_ff | q_ovf | pse_pkg::ovf34(sum);
            end
            default: begin
               sum     = 34'(acc_ff) + 34'(q);
               acc_in  = pse_pkg::sat34(sum);
               tm2_in  = tm1_ff;
               tm1_in  = t_ff;
               flag_in = flag_ff | q_ovf | pse_pkg::ovf34(sum);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pse_pkg::MaxOrder; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (cmd.load_en) begin
         coeff_ff[coeff_index] <= coeff_value;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      v_ff    <= v_in;
      s_ff    <= s_in;
      tm1_ff  <= tm1_in;
      tm2_ff  <= tm2_in;
      t_ff    <= t_in;
      m_ff    <= m_in;
      p1_ff   <= p1_in;
      acc_ff  <= acc_in;
      flag_ff <= flag_in;
      if (cmd.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (cmd.out_ld) begin
         fit_ff <= acc_ff;
         sat_ff <= flag_ff;
      end
   end

endmodule

// ===== hw/rtl/poly_series_eval_1d.sv =====
`timescale 1ns / 1ps
// An evaluate word holds the block while its steps run in turn on one shared multiplier;
// their number depends on the mode and the term count. The result becomes valid in the
// same cycle that the block is ready for a new word again. A load word does not hold
// the block. One word is in work at a time, and a finished result waits in an output
// register, holding the block while the previous result is not yet taken. Reset is
// synchronous and active high; it clears the coefficient store, control and settings.

module poly_series_eval_1d (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // coeff_index, coeff_value, coord_x, zero pad
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // fit_value, saturated, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [1:0]           mode_ff;
   logic [3:0]           terms_ff;
   logic signed [31:0]   offset_ff;
   logic signed [31:0]   scale_ff;
   pse_pkg::pse_cmd_type cmd;
   logic signed [31:0]   fit_value;
   logic                 saturated;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {7'd0, saturated, fit_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         terms_ff  <= 4'd1;
         offset_ff <= '0;
         scale_ff  <= pse_pkg::ONE_Q;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pse_pkg::CSR_MODE:   mode_ff   <= csr_data[1:0];
            pse_pkg::CSR_TERMS:  terms_ff  <= csr_data[3:0];
            pse_pkg::CSR_OFFSET: offset_ff <= csr_data;
            pse_pkg::CSR_SCALE:  scale_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   pse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_command (req_tuser),
      .req_ready   (req_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .series_mode (mode_ff),
      .term_count  (terms_ff),
      .cmd         (cmd)
   );

   pse_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .coeff_index (req_tdata[2:0]),
      .coeff_value (req_tdata[34:3]),
      .coord_x     (req_tdata[66:35]),
      .norm_offset (offset_ff),
      .norm_scale  (scale_ff),
      .fit_value   (fit_value),
      .saturated   (saturated)
   );

endmodule

// ===== hw/rtl/pse_checker.sv =====
`timescale 1ns / 1ps

module pse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == pse_pkg::CMD_EVAL) |=> !req_tready)
      else $error("input taken right after an evaluate word");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == pse_pkg::CMD_LOAD) |=> req_tready)
      else $error("load word stalled the input");

   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind poly_series_eval_1d pse_checker u_pse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ===== dv/poly_series_eval_1d_test.sv =====
`timescale 1ns / 1ps

module poly_series_eval_1d_test;

   typedef struct {
      logic        cmd;
      logic [2:0]  idx;
      logic [31:0] val;
      logic [31:0] x;
      int          gap;
   } word_type;

   typedef struct {
      logic [31:0] fit;
      logic        sat;
   } fit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   poly_series_eval_1d dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   word_type pending_words[$];
   fit_type  expected_fits[$];
   logic [1:0]         mode_q;
   logic [3:0]         terms_q;
   logic signed [31:0] offset_q, scale_q;
   logic signed [31:0] coeffs[8];
   int  mismatches = 0, fits_seen = 0, words_sent = 0;
   int  hold_off = 0;
   bit  driving = 1'b0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;

   function automatic longint clip(longint v, ref bit f);
      if (v > 64'sd2147483647) begin
         f = 1; return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         f = 1; return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b, ref bit f);
      longint p;
      p = a * b;
      return clip(p >>> pse_pkg::FracBits, f);
   endfunction

   function automatic longint ratio_a(longint j);
      return (((2 * j - 1) << pse_pkg::FracBits) + j / 2) / j;
   endfunction

   function automatic longint ratio_b(longint j);
      return -((((j - 1) << pse_pkg::FracBits) + j / 2) / j);
   endfunction

   function automatic fit_type series_value(logic signed [31:0] xin);
      bit      f;
      longint  x, s, acc, tm1, tm2, t, m, n;
      fit_type r;
      f = 0;
      x = longint'(xin);
      n = longint'(terms_q);
      if (n < 1) n = 1;
      if (n > pse_pkg::MaxOrder) n = pse_pkg::MaxOrder;
      acc = longint'(coeffs[0]);
      if (mode_q == pse_pkg::MODE_CHEB || mode_q == pse_pkg::MODE_LEG) begin
         s = qmul(clip(x + longint'(offset_q), f), longint'(scale_q), f);
         tm2 = longint'(pse_pkg::ONE_Q);
         tm1 = s;
         if (n >= 2) acc = clip(acc + qmul(longint'(coeffs[1]), s, f), f);
         for (longint j = 2; j < n; j++) begin
            m = qmul(s, tm1, f);
            if (mode_q == pse_pkg::MODE_CHEB) t = clip(2 * m - tm2, f);
            else t = clip(qmul(m, ratio_a(j), f) + qmul(tm2, ratio_b(j), f), f);
            acc = clip(acc + qmul(longint'(coeffs[j]), t, f), f);
            tm2 = tm1;
            tm1 = t;
         end
      end else begin
         t = x;
         for (longint j = 1; j < n; j++) begin
            if (j > 1) t = qmul(t, x, f);
            acc = clip(acc + qmul(t, longint'(coeffs[j]), f), f);
         end
      end
      r.fit = acc[31:0];
      r.sat = f;
      return r;
   endfunction

   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 131072) - 65536;
         3: return $urandom_range(0, 1 << 20) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_word(logic cmd, logic [2:0] idx, logic [31:0] val, logic [31:0] x);
      word_type w;
      w.cmd = cmd; w.idx = idx; w.val = val; w.x = x;
      w.gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
      pending_words.push_back(w);
   endtask

   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser == pse_pkg::CMD_LOAD) begin
            coeffs[req_tdata[2:0]] <= req_tdata[34:3];
         end else begin
            expected_fits.push_back(series_value(req_tdata[66:35]));
         end
      end
   end

   int gap_left = 0;
   always @(negedge clock) begin
      word_type w;
      if (req_taken) words_sent++;
      if (req_tvalid && !req_taken) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (driving && pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_tvalid <= 1'b1;
         req_tuser <= w.cmd;
         req_tdata <= {5'd0, w.x, w.val, w.idx};
         gap_left = w.gap;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   int stall_left = 0;
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else if (rsp_taken) begin
         stall_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
         rsp_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      fit_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         fits_seen++;
         if (expected_fits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            e = expected_fits.pop_front();
            if (rsp_tdata[31:0] !== e.fit || rsp_tdata[32] !== e.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected fit %h sat %b, got fit %h sat %b",
                           fits_seen, e.fit, e.sat, rsp_tdata[31:0], rsp_tdata[32]);
            end
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         pse_pkg::CSR_MODE:   mode_q = data[1:0];
         pse_pkg::CSR_TERMS:  terms_q = data[3:0];
         pse_pkg::CSR_OFFSET: offset_q = data;
         default:             scale_q = data;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      driving = 1'b1;
      while (pending_words.size() > 0 || req_tvalid || expected_fits.size() > 0)
         @(posedge clock);
      driving = 1'b0;
      repeat (40) @(posedge clock);
   endtask

   task automatic setup(logic [1:0] m, logic [3:0] n, logic [31:0] o, logic [31:0] s);
      write_csr(pse_pkg::CSR_MODE, 32'(m));
      write_csr(pse_pkg::CSR_TERMS, 32'(n));
      write_csr(pse_pkg::CSR_OFFSET, o);
      write_csr(pse_pkg::CSR_SCALE, s);
   endtask

   initial begin
      mode_q = 0; terms_q = 1; offset_q = 0; scale_q = 32'sd65536;
      foreach (coeffs[i]) coeffs[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      queue_word(pse_pkg::CMD_EVAL, 3'd7, 32'hFFFFFFFF, 32'h00010000);
      for (int i = 0; i < 8; i++)
         queue_word(pse_pkg::CMD_LOAD, i[2:0], 32'h00008000 + i * 32'h1000, $urandom);
      drain();
      setup(2'd0, 4'd8, 32'h7FFFFFFF, 32'h80000000);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'h7FFFFFFF);
      queue_word(pse_pkg::CMD_EVAL, 3'd5, 32'h7FFFFFFF, 32'h80000000);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'h00000000);
      drain();
      setup(pse_pkg::MODE_CHEB, 4'd15, 32'h80000000, 32'h7FFFFFFF);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'h80000000);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'h00008000);
      drain();
      setup(pse_pkg::MODE_LEG, 4'd0, 32'h0, 32'h00010000);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'h00004000);
      drain();
      write_csr(pse_pkg::CSR_TERMS, 32'd8);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'hFFFF8000);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'h7FFFFFFF);
      drain();
      setup(2'd3, 4'd4, 32'h0, 32'h00010000);
      queue_word(pse_pkg::CMD_EVAL, 3'd0, 32'h0, 32'h00018000);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         setup(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), rand_q(), rand_q());
         for (int k = 0; k < 55; k++) begin
            if ($urandom_range(0, 4) == 0)
               queue_word(pse_pkg::CMD_LOAD, 3'($urandom_range(0, 7)), rand_q(), $urandom);
            else
               queue_word(pse_pkg::CMD_EVAL, 3'($urandom_range(0, 7)), $urandom, rand_q());
         end
         if (phase == 2) hold_off = 400;
         drain();
      end

      if (mismatches == 0) begin
         $display("Covered all modes, term counts 0..15, extreme offsets and scales.");
         $display("%0d words sent, %0d results checked.", words_sent, fits_seen);
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches over %0d results.", mismatches, fits_seen);
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/pse_pkg.sv
hw/rtl/pse_ctrl.sv
hw/rtl/pse_dpath.sv
hw/rtl/poly_series_eval_1d.sv
hw/rtl/pse_checker.sv
dv/poly_series_eval_1d_test.sv
